FILE: hdl/itp_pkg.sv
// itp_pkg: types, character codes and helper functions for the infix to postfix converter
// used by itp_ctrl, itp_datapath and infix_to_postfix_converter; no dependencies
`default_nettype none

package itp_pkg;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       has_symbol;
        logic       run_last;
        logic       expr_end;
        logic       overflow;
    } out_item_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic emit_sym;
        logic push;
        logic pop_emit;
        logic pop_drop;
        logic finish;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_alnum;
        logic is_lparen;
        logic is_rparen;
        logic fin;
        logic stack_empty;
        logic top_is_lparen;
        logic top_pops;
        logic out_free;
    } status_t;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            p = 2'd1;
        end
        else if ((c == CH_STAR) || (c == CH_SLASH)) begin
            p = 2'd2;
        end
        else if (c == CH_CARET) begin
            p = 2'd3;
        end
        return p;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

`default_nettype wire

FILE: hdl/itp_ctrl.sv
// itp_ctrl: sequencer for the infix to postfix converter
// depends on itp_pkg (cmd_t, status_t)
`default_nettype none

module itp_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               sym_valid,
    output logic              sym_stall,
    input  itp_pkg::status_t  st,
    output itp_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign sym_stall = (state_reg != S_IDLE);

    always_comb
    begin
        logic [1:0] after;
        after      = st.fin ? S_FLUSH : S_DONE;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sym_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (st.out_free) begin
                    if (st.is_alnum) begin
                        cmd.emit_sym = 1'b1;
                        state_next   = after;
                    end
                    else if (st.is_lparen) begin
                        cmd.push   = 1'b1;
                        state_next = after;
                    end
                    else if (st.is_rparen) begin
                        if (!st.stack_empty && !st.top_is_lparen) begin
                            cmd.pop_emit = 1'b1;
                        end
                        else begin
                            // matching bracket is discarded
                            cmd.pop_drop = !st.stack_empty;
                            state_next   = after;
                        end
                    end
                    else begin
                        if (!st.stack_empty && st.top_pops) begin
                            cmd.pop_emit = 1'b1;
                        end
                        else begin
                            cmd.push   = 1'b1;
                            state_next = after;
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                if (st.out_free) begin
                    if (!st.stack_empty) begin
                        cmd.pop_emit = 1'b1;
                    end
                    else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/itp_datapath.sv
// itp_datapath: operator stack, held-back result and output register
// depends on itp_pkg (types, character codes, prec_of, is_alnum)
`default_nettype none

module itp_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  itp_pkg::in_item_t   sym_item,
    input  itp_pkg::cmd_t       cmd,
    output itp_pkg::status_t    st,
    output logic                pf_valid,
    input  wire                 pf_stall,
    output itp_pkg::out_item_t  pf_item
);

    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam int IDXW = $clog2(STACK_DEPTH);
    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(STACK_DEPTH);

    logic [7:0]      stack_reg [STACK_DEPTH];
    logic [CNTW-1:0] count_reg;
    logic            ovf_reg;
    logic [7:0]      sym_reg;
    logic            fin_reg;
    logic [7:0]      pend_sym_reg;
    logic            pend_valid_reg;
    logic            out_valid_reg;
    itp_pkg::out_item_t out_reg;

    logic [CNTW-1:0] count_m1;
    logic [7:0]      top_sym;
    logic            out_free;
    logic            new_res;
    logic [7:0]      new_sym;

    assign count_m1 = count_reg - 1'b1;
    assign top_sym  = stack_reg[count_m1[IDXW-1:0]];
    assign out_free = !out_valid_reg || !pf_stall;
    assign new_res  = cmd.pop_emit || cmd.emit_sym;
    assign new_sym  = cmd.pop_emit ? top_sym : sym_reg;

    always_comb
    begin
        st.is_alnum      = itp_pkg::is_alnum(sym_reg);
        st.is_lparen     = (sym_reg == itp_pkg::CH_LPAREN);
        st.is_rparen     = (sym_reg == itp_pkg::CH_RPAREN);
        st.fin           = fin_reg;
        st.stack_empty   = (count_reg == '0);
        st.top_is_lparen = (top_sym == itp_pkg::CH_LPAREN);
        st.top_pops      = (itp_pkg::prec_of(top_sym) >= itp_pkg::prec_of(sym_reg));
        st.out_free      = out_free;
    end

    // stack storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.push && (count_reg < DEPTH_C)) begin
            stack_reg[count_reg[IDXW-1:0]] <= sym_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            sym_reg <= sym_item.symbol;
            fin_reg <= sym_item.final_char;
        end
        if (new_res) begin
            pend_sym_reg <= new_sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else begin
            if (cmd.push) begin
                if (count_reg < DEPTH_C) begin
                    count_reg <= count_reg + 1'b1;
                end
                else begin
                    ovf_reg <= 1'b1;
                end
            end
            else if (cmd.pop_emit || cmd.pop_drop) begin
                count_reg <= count_m1;
            end
            else if (cmd.finish && fin_reg) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (new_res) begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // a result is held back one step so that run_last is known when it leaves
    logic load_out;
    assign load_out = (new_res && pend_valid_reg) ||
                      (cmd.finish && (pend_valid_reg || fin_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out) begin
            out_valid_reg <= 1'b1;
        end
        else if (!pf_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out) begin
            out_reg.out_symbol <= pend_valid_reg ? pend_sym_reg : 8'd0;
            out_reg.has_symbol <= pend_valid_reg;
            out_reg.run_last   <= cmd.finish;
            out_reg.expr_end   <= cmd.finish && fin_reg;
            out_reg.overflow   <= ovf_reg;
        end
    end

    assign pf_valid = out_valid_reg;
    assign pf_item  = out_reg;

endmodule

`default_nettype wire

FILE: hdl/infix_to_postfix_converter.sv
// infix_to_postfix_converter: top level, joins the sequencer and the stack datapath
// depends on itp_pkg, itp_ctrl and itp_datapath
`default_nettype none

// Takes one infix character per item on the sym channel and sends the postfix
// characters it releases on the pf channel, each result held back one step so
// that run_last and expr_end can be set on it. Each item is accepted, then
// evaluated, popping and emitting stack entries one at a time through the single
// stack port while it is evaluated (a matching open bracket is dropped in the
// evaluate step); after a final item the stack is flushed, and a closing step
// ends every item. Steps wait while the output register is full and stalled. A
// new item is taken only between items.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 sym_valid,
    output logic                sym_stall,
    input  itp_pkg::in_item_t   sym_item,
    output logic                pf_valid,
    input  wire                 pf_stall,
    output itp_pkg::out_item_t  pf_item
);

    itp_pkg::cmd_t    cmd;
    itp_pkg::status_t st;

    itp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .st        (st),
        .cmd       (cmd)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .sym_item (sym_item),
        .cmd      (cmd),
        .st       (st),
        .pf_valid (pf_valid),
        .pf_stall (pf_stall),
        .pf_item  (pf_item)
    );

endmodule

`default_nettype wire
